>>> rtl/swam_pkg.sv
// ----------------------------------------------------------------------------
// swam_pkg
// shared types and constants for the sensor window average monitor
// ----------------------------------------------------------------------------
package swam_pkg;

    localparam int TABLE_ENTRIES = 32;
    localparam int WINDOW_LENGTH = 8;
    localparam int EIDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int WPTR_W = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
    localparam int FILL_W = $clog2(WINDOW_LENGTH + 1);
    localparam int SAMP_ADDR_W = $clog2(TABLE_ENTRIES * WINDOW_LENGTH);
    localparam int SUM_W  = 16 + $clog2(WINDOW_LENGTH) + 1;
    localparam int SHIFT  = $clog2(WINDOW_LENGTH);
    localparam int QDEPTH = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TEMP = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_TEMP = 1'd1;

    localparam logic OP_MAP    = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef enum logic [2:0] {
        ST_LOADED     = 3'd0,
        ST_NOT_FULL   = 3'd1,
        ST_IN_RANGE   = 3'd2,
        ST_TOO_HOT    = 3'd3,
        ST_TOO_COLD   = 3'd4,
        ST_UNKNOWN    = 3'd5,
        ST_TABLE_FULL = 3'd6
    } status_t;

    typedef struct packed {
        logic               opcode;
        logic [15:0]        sensor_id;
        logic [15:0]        room_id;
        logic signed [15:0] sample_value;
        logic [31:0]        timestamp;
    } cmd_t;

    typedef struct packed {
        status_t            status;
        logic [15:0]        sensor_id;
        logic [15:0]        room_id;
        logic signed [15:0] average;
    } rsp_t;

    typedef enum logic [2:0] {
        EX_IDLE,
        EX_SEARCH,
        EX_READ,
        EX_SUM,
        EX_DONE
    } ex_state_t;

endpackage

>>> rtl/swam_if.sv
// ----------------------------------------------------------------------------
// swam_cmd_if / swam_rsp_if
// valid/ready channels for command and result beats
// ----------------------------------------------------------------------------
interface swam_cmd_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic [15:0]        sensor_id;
    logic [15:0]        room_id;
    logic signed [15:0] sample_value;
    logic [31:0]        timestamp;
    modport source (output valid, opcode, sensor_id, room_id, sample_value, timestamp,
                    input ready);
    modport sink (input valid, opcode, sensor_id, room_id, sample_value, timestamp,
                  output ready);
endinterface

interface swam_rsp_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic [15:0]        sensor_id_out;
    logic [15:0]        room_id_out;
    logic signed [15:0] average;
    modport source (output valid, status, sensor_id_out, room_id_out, average,
                    input ready);
    modport sink (input valid, status, sensor_id_out, room_id_out, average,
                  output ready);
endinterface

>>> rtl/swam_queue.sv
// ----------------------------------------------------------------------------
// swam_queue
// short fifo of command beats between front and back
// ----------------------------------------------------------------------------
module swam_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  swam_pkg::cmd_t  push_data,
    output logic            full,
    input  logic            pop,
    output swam_pkg::cmd_t  pop_data,
    output logic            empty
);
    import swam_pkg::*;

    localparam int PTR_W = $clog2(QDEPTH);

    cmd_t             mem_reg [QDEPTH];
    logic [PTR_W-1:0] wr_reg, rd_reg;
    logic [PTR_W:0]   cnt_reg;

    assign full     = (cnt_reg == (PTR_W+1)'(QDEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_data = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
            mem_reg[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push && !full)
                wr_reg <= wr_reg + 1'b1;
            if (pop && !empty)
                rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (PTR_W+1)'(push && !full) - (PTR_W+1)'(pop && !empty);
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |=> cnt_reg <= (PTR_W+1)'(QDEPTH))
        else $error("queue count overflow");
    a_pop_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !push) |=> cnt_reg == $past(cnt_reg) - 1'b1)
        else $error("pop did not drain");
    a_push_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && !(pop && !empty)) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("push did not fill");
endmodule

>>> rtl/swam_exec.sv
// ----------------------------------------------------------------------------
// swam_exec
// table load, table search, window update, window sum and threshold compare
// ----------------------------------------------------------------------------
module swam_exec (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cmd_valid,
    input  swam_pkg::cmd_t         cmd,
    output logic                   cmd_pop,
    input  logic signed [15:0]     max_temp,
    input  logic signed [15:0]     min_temp,
    output logic                   rsp_valid,
    input  logic                   rsp_ready,
    output swam_pkg::rsp_t         rsp
);
    import swam_pkg::*;

    logic [15:0]              sid_mem [TABLE_ENTRIES];
    logic [15:0]              rid_mem [TABLE_ENTRIES];
    logic [31:0]              ts_mem  [TABLE_ENTRIES];
    logic [15:0]              samp_mem [TABLE_ENTRIES*WINDOW_LENGTH];
    logic [WPTR_W-1:0]        wptr_reg [TABLE_ENTRIES];
    logic [FILL_W-1:0]        fill_reg [TABLE_ENTRIES];

    ex_state_t                state_reg, state_next;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         idx_reg, idx_next;
    logic [WPTR_W:0]          k_reg, k_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic [15:0]              sid_rd_reg, rid_rd_reg, samp_rd_reg;
    logic                     rsp_valid_reg;
    rsp_t                     rsp_reg;
    logic [EIDX_W-1:0]        eidx;
    logic [SAMP_ADDR_W-1:0]   samp_raddr;
    logic signed [15:0]       avg;
    logic                     full_win;

    assign eidx      = idx_reg[EIDX_W-1:0];
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign avg       = 16'(sum_reg >>> SHIFT);
    assign full_win  = (fill_reg[eidx] == FILL_W'(WINDOW_LENGTH));
    assign samp_raddr = SAMP_ADDR_W'(eidx) * SAMP_ADDR_W'(WINDOW_LENGTH)
                      + SAMP_ADDR_W'(k_reg[WPTR_W-1:0]);

    // registered reads from the id table and the sample memory
    always_ff @(posedge clk)
    begin
        sid_rd_reg  <= sid_mem[eidx];
        rid_rd_reg  <= rid_mem[eidx];
        samp_rd_reg <= samp_mem[samp_raddr];
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        k_next     = k_reg;
        sum_next   = sum_reg;
        cmd_pop    = 1'b0;
        unique case (state_reg)
            EX_IDLE:
            begin
                idx_next = '0;
                if (cmd_valid && !rsp_valid_reg)
                begin
                    if (cmd.opcode == OP_MAP)
                    begin
                        state_next = EX_DONE;
                    end
                    else
                    begin
                        state_next = EX_SEARCH;
                    end
                end
            end
            EX_SEARCH:
            begin
                // read data for idx_reg is registered; it is ready in EX_READ
                state_next = EX_READ;
            end
            EX_READ:
            begin
                if (idx_reg >= count_reg)
                    state_next = EX_DONE;
                else if (sid_rd_reg == cmd.sensor_id)
                begin
                    state_next = EX_DONE;
                    if (fill_reg[eidx] >= FILL_W'(WINDOW_LENGTH - 1))
                    begin
                        state_next = EX_SUM;
                        k_next     = '0;
                        sum_next   = '0;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = EX_SEARCH;
                end
            end
            EX_SUM:
            begin
                // window already holds the new sample; one read per cycle
                if (k_reg != '0)
                    sum_next = sum_reg + SUM_W'(signed'(samp_rd_reg));
                if (k_reg == (WPTR_W+1)'(WINDOW_LENGTH))
                    state_next = EX_DONE;
                else
                    k_next = k_reg + 1'b1;
            end
            EX_DONE:
            begin
                cmd_pop    = 1'b1;
                state_next = EX_IDLE;
            end
            default: state_next = EX_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= EX_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            idx_reg       <= '0;
            k_reg         <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            k_reg     <= k_next;
            if (rsp_valid_reg && rsp_ready)
                rsp_valid_reg <= 1'b0;
            if (state_reg == EX_DONE)
            begin
                rsp_valid_reg <= 1'b1;
                if (cmd.opcode == OP_MAP && count_reg < CNT_W'(TABLE_ENTRIES))
                    count_reg <= count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        if (state_reg == EX_IDLE && cmd_valid && !rsp_valid_reg && cmd.opcode == OP_MAP
            && count_reg < CNT_W'(TABLE_ENTRIES))
        begin
            sid_mem[count_reg[EIDX_W-1:0]]  <= cmd.sensor_id;
            rid_mem[count_reg[EIDX_W-1:0]]  <= cmd.room_id;
            wptr_reg[count_reg[EIDX_W-1:0]] <= '0;
            fill_reg[count_reg[EIDX_W-1:0]] <= '0;
        end
        if (state_reg == EX_READ && idx_reg < count_reg && sid_rd_reg == cmd.sensor_id)
        begin
            samp_mem[SAMP_ADDR_W'(eidx) * SAMP_ADDR_W'(WINDOW_LENGTH)
                     + SAMP_ADDR_W'(wptr_reg[eidx])] <= cmd.sample_value;
            wptr_reg[eidx] <= (wptr_reg[eidx] == WPTR_W'(WINDOW_LENGTH - 1))
                              ? '0 : wptr_reg[eidx] + 1'b1;
            if (!full_win)
                fill_reg[eidx] <= fill_reg[eidx] + 1'b1;
            ts_mem[eidx] <= cmd.timestamp;
        end
        if (state_reg == EX_DONE)
        begin
            rsp_reg.sensor_id <= cmd.sensor_id;
            rsp_reg.average   <= '0;
            rsp_reg.room_id   <= '0;
            if (cmd.opcode == OP_MAP)
            begin
                if (count_reg < CNT_W'(TABLE_ENTRIES))
                begin
                    rsp_reg.status  <= ST_LOADED;
                    rsp_reg.room_id <= cmd.room_id;
                end
                else
                    rsp_reg.status <= ST_TABLE_FULL;
            end
            else if (idx_reg >= count_reg)
                rsp_reg.status <= ST_UNKNOWN;
            else
            begin
                rsp_reg.room_id <= rid_rd_reg;
                if (!full_win || k_reg == '0)
                    rsp_reg.status <= ST_NOT_FULL;
                else
                begin
                    rsp_reg.average <= avg;
                    if (avg > max_temp)
                        rsp_reg.status <= ST_TOO_HOT;
                    else if (avg < min_temp)
                        rsp_reg.status <= ST_TOO_COLD;
                    else
                        rsp_reg.status <= ST_IN_RANGE;
                end
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_ENTRIES))
        else $error("entry count beyond table");
    a_done_gives_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == EX_DONE |=> rsp_valid_reg)
        else $error("finished item without result");
    a_start_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == EX_IDLE && state_next != EX_IDLE) |-> !rsp_valid_reg)
        else $error("item started while result pending");
endmodule

>>> rtl/sensor_window_average_monitor.sv
// ----------------------------------------------------------------------------
// sensor_window_average_monitor
// per-sensor moving average with hot/cold threshold reporting
// ----------------------------------------------------------------------------
// usage
//   cmd (sink): one beat per item; opcode map loads a table entry, opcode
//   sample looks up the sensor, stores the sample and, once its window is
//   full, reports the floor average against max_temp / min_temp
//   rsp (source): exactly one beat per command, in command order
//   cfg: write enable, index (0 max_temp, 1 min_temp) and data
// sequencing
//   map beat: written into the table, then straight to the result
//   sample beat: a search state and a read state per table entry searched
//   (registered table read), then the window sum state when the window is
//   full, then the result
//   the back end starts the next item only after the result is taken
// reset
//   entry count and thresholds return to defaults, no memory sweep needed
// stall
//   a held result blocks the back end; the two-deep queue keeps taking beats
//   until full, then ready drops
// ----------------------------------------------------------------------------
module sensor_window_average_monitor (
    input  logic        clk,
    input  logic        rst_n,
    swam_cmd_if.sink    cmd,
    swam_rsp_if.source  rsp,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import swam_pkg::*;

    logic               q_full, q_empty, q_pop;
    cmd_t               q_in, q_out;
    rsp_t               r;
    logic signed [15:0] max_temp_reg, min_temp_reg;

    // front: accept and pack beats into the queue
    assign cmd.ready = !q_full;
    assign q_in = '{opcode: cmd.opcode, sensor_id: cmd.sensor_id, room_id: cmd.room_id,
                    sample_value: cmd.sample_value, timestamp: cmd.timestamp};

    // threshold registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_temp_reg <= 16'sd6400;
            min_temp_reg <= 16'sd3840;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAX_TEMP: max_temp_reg <= cfg_data;
                CFG_MIN_TEMP: min_temp_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    swam_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd.valid),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    // back: load, search, update, average and compare
    swam_exec u_exec (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!q_empty),
        .cmd       (q_out),
        .cmd_pop   (q_pop),
        .max_temp  (max_temp_reg),
        .min_temp  (min_temp_reg),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .rsp       (r)
    );

    assign rsp.status        = r.status;
    assign rsp.sensor_id_out = r.sensor_id;
    assign rsp.room_id_out   = r.room_id;
    assign rsp.average       = r.average;
endmodule
